// ----- rtl/accept_encoding_token_matcher_defines.svh -----
// Assertion macros shared by the accept encoding token matcher RTL.
`ifndef ACCEPT_ENCODING_TOKEN_MATCHER_DEFINES_SVH
`define ACCEPT_ENCODING_TOKEN_MATCHER_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define AETM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold at every rising clock edge outside reset.
`define AETM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- rtl/aetm_pkg.sv -----
// Package with the keyword table and byte constants of the token matcher.
package aetm_pkg;

  localparam int unsigned TOKEN_MAX_LEN_DEF = 8;
  localparam int unsigned KW_COUNT          = 6;
  // Longest keyword; only this many token bytes are ever compared.
  localparam int unsigned KW_BUF_LEN        = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef logic [7:0] byte_t;
  typedef logic [KW_COUNT-1:0] kw_mask_t;

  localparam byte_t KW_TEXT [KW_COUNT][KW_BUF_LEN] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // empty
    '{"g", "z", "i", "p", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "m", "p", "r", "e", "s", "s"},
    '{"d", "e", "f", "l", "a", "t", "e", 8'h00},
    '{"b", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"z", "s", "t", "d", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd0, 4'd4, 4'd8, 4'd7, 4'd2, 4'd4};

  function automatic byte_t fold_case(input byte_t c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

// ----- rtl/accept_encoding_token_matcher.sv -----
// A final item passes through the input register and then the result register before its mask is on the outputs.
// Throughput: one item per cycle unless stalled; an input register feeds the token logic,
// which loads a result register holding the mask of a final item.
// The input side stalls only while a final item waits on a stalled result.
// Reset (synchronous, rst_n low) empties the token, clears the mask and
// suffix/halt flags, and drops both the input and result valid bits.
`include "accept_encoding_token_matcher_defines.svh"

module accept_encoding_token_matcher
  import aetm_pkg::*;
#(
  parameter int unsigned TOKEN_MAX_LEN = TOKEN_MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_encoding_mask
);

  // Length saturates at TOKEN_MAX_LEN + 1, which marks an overlong token.
  localparam int unsigned LEN_W = $clog2(TOKEN_MAX_LEN + 2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TOKEN_MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_BUF = LEN_W'(KW_BUF_LEN);

  logic             s1_valid_r;
  byte_t            s1_char_r;
  logic             s1_fin_r;
  logic             s1_adv;
  logic             in_acc;

  byte_t            buf_r   [KW_BUF_LEN];
  byte_t            buf_nxt [KW_BUF_LEN];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             suffix_r, suffix_nxt;
  logic             halted_r, halted_nxt;
  kw_mask_t         found_r, found_nxt;

  logic             out_valid_r;
  kw_mask_t         out_mask_r;

  // A final item may only move on when the result register is free.
  assign s1_adv   = s1_valid_r && !(s1_fin_r && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    logic             do_append;
    logic             ends;
    logic [LEN_W-1:0] app_len;
    byte_t            app_buf [KW_BUF_LEN];
    logic             same;
    kw_mask_t         hit;

    do_append  = 1'b0;
    ends       = 1'b0;
    suffix_nxt = suffix_r;
    halted_nxt = halted_r;
    len_nxt    = len_r;
    found_nxt  = found_r;

    if (!halted_r) begin
      priority if (s1_char_r == CH_NUL) begin
        halted_nxt = 1'b1;
      end else if (s1_char_r == CH_SPACE) begin
        len_nxt = '0;
      end else if (s1_char_r == CH_SEMI) begin
        ends       = 1'b1;
        suffix_nxt = 1'b1;
      end else if (s1_char_r == CH_COMMA) begin
        ends       = !suffix_r;
        do_append  = suffix_r;
        suffix_nxt = 1'b0;
      end else begin
        do_append = 1'b1;
        ends      = s1_fin_r;
      end
    end

    // Token view after the current byte is appended.
    for (int i = 0; i < KW_BUF_LEN; i++) begin
      app_buf[i] = (do_append && len_r == LEN_W'(i)) ? s1_char_r : buf_r[i];
    end
    app_len = (do_append && len_r <= LEN_MAX) ? len_r + 1'b1 : len_r;
    if (do_append) begin
      len_nxt = app_len;
    end

    for (int k = 0; k < KW_COUNT; k++) begin
      same = (app_len == LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_BUF_LEN; i++) begin
        if (4'(i) < KW_LEN[k] && fold_case(app_buf[i]) != KW_TEXT[k][i]) begin
          same = 1'b0;
        end
      end
      hit[k] = same;
    end

    if (ends) begin
      if (app_len <= LEN_MAX) begin
        found_nxt = found_r | hit;
      end
      len_nxt = '0;
    end

    for (int i = 0; i < KW_BUF_LEN; i++) begin
      buf_nxt[i] = (do_append && app_len <= LEN_BUF) ? app_buf[i] : buf_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      suffix_r    <= 1'b0;
      halted_r    <= 1'b0;
      found_r     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_fin_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_fin_r) begin
          len_r    <= '0;
          suffix_r <= 1'b0;
          halted_r <= 1'b0;
          found_r  <= '0;
        end else begin
          len_r    <= len_nxt;
          suffix_r <= suffix_nxt;
          halted_r <= halted_nxt;
          found_r  <= found_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_in;
      s1_fin_r  <= in_is_final;
    end
    if (s1_adv) begin
      buf_r <= buf_nxt;
    end
    if (s1_adv && s1_fin_r) begin
      out_mask_r <= found_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_encoding_mask = out_mask_r;

  `AETM_ASSERT_ALWAYS(a_len_bound, len_r <= LEN_MAX + 1'b1, "token length past saturation")
  `AETM_ASSERT_IMP(a_final_clears, s1_adv && s1_fin_r,
    ##1 (len_r == '0 && found_r == '0 && !halted_r && !suffix_r),
    "state not cleared after final item")
  `AETM_ASSERT_IMP(a_out_from_final, $rose(out_valid_r), $past(s1_adv && s1_fin_r),
    "result appeared without a final item")
  `AETM_ASSERT_IMP(a_stall_cause, in_stall,
    s1_valid_r && s1_fin_r && out_valid_r && out_stall,
    "input stalled without a blocked final item")

endmodule
